// ===== src/pbwa_pkg.sv =====
// Shared types and constants for the PCI BAR window allocator.
package pbwa_pkg;

  localparam int WINDOWS  = 2;
  localparam int WIN_W    = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int WC_W     = 2;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 64;
  localparam int ADDR_W   = 64;
  localparam int WORD_W   = 32;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 3;

  localparam logic [ADDR_W-1:0] IO_REACH       = 64'h0000_0000_0000_ffff;
  localparam logic [ADDR_W-1:0] MEM20_REACH    = 64'h0000_0000_000f_ffff;
  localparam logic [ADDR_W-1:0] MEM32_REACH    = 64'h0000_0000_ffff_ffff;
  localparam logic [ADDR_W-1:0] MEM64_REACH    = 64'hffff_ffff_ffff_ffff;
  localparam logic [ADDR_W-1:0] IO_ALIGN_MASK  = ~64'd3;
  localparam logic [ADDR_W-1:0] MEM_ALIGN_MASK = ~64'd15;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_WINDOW_COUNT = 3'd0,
    CFG_WIN0_IS_IO   = 3'd1,
    CFG_WIN0_BASE    = 3'd2,
    CFG_WIN0_SIZE    = 3'd3,
    CFG_WIN1_IS_IO   = 3'd4,
    CFG_WIN1_BASE    = 3'd5,
    CFG_WIN1_SIZE    = 3'd6
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_KEPT     = 3'd0,
    ST_ASSIGNED = 3'd1,
    ST_INVALID  = 3'd2,
    ST_NO_FIT   = 3'd3,
    ST_REFUSED  = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic size_en;
    logic win_a_en;
    logic win_b_en;
    logic widx_inc;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic empty;
    logic fit;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== src/pbwa_ctrl.sv =====
// Controller state machine sequencing decode, window scan and commit.
module pbwa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbwa_pkg::stat_t   stat,
  output pbwa_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SIZE   = 5'b00010,
    S_WIN_A  = 5'b00100,
    S_WIN_B  = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size_en = 1'b1;
        if (stat.bad || stat.empty) begin
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_WIN_A;
        end
      end
      S_WIN_A: begin
        cmd.win_a_en = 1'b1;
        state_nxt    = S_WIN_B;
      end
      S_WIN_B: begin
        cmd.win_b_en = 1'b1;
        if (stat.fit || stat.last) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.widx_inc = 1'b1;
          state_nxt    = S_WIN_A;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/pbwa_dp.sv =====
// Datapath: window registers, cursors, BAR decode, fit checks and result register.
module pbwa_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pbwa_pkg::CFG_IX_W-1:0]      cfg_index,
  input  logic [pbwa_pkg::CFG_D_W-1:0]       cfg_data,
  input  logic [pbwa_pkg::SLOT_W-1:0]        in_bar_index,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_bar_low,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_bar_high,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_mask_low,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_mask_high,
  input  logic                               in_device_accepts,
  input  pbwa_pkg::cmd_t                     cmd,
  output pbwa_pkg::stat_t                    stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbwa_pkg::STATUS_W-1:0]      out_status,
  output logic [pbwa_pkg::WORD_W-1:0]        out_assigned_low,
  output logic [pbwa_pkg::WORD_W-1:0]        out_assigned_high,
  output logic                               out_window_used
);

  localparam int AW = pbwa_pkg::ADDR_W;
  localparam int WW = pbwa_pkg::WORD_W;

  localparam logic [1:0] MEM_TYPE_20   = 2'd1;
  localparam logic [1:0] MEM_TYPE_64   = 2'd2;
  localparam logic [1:0] MEM_TYPE_RSVD = 2'd3;
  localparam logic [pbwa_pkg::SLOT_W-1:0] FIRST_BAD_SLOT = 3'd6;
  localparam logic [pbwa_pkg::SLOT_W-1:0] LAST_SLOT      = 3'd5;

  // configuration and cursors
  logic [pbwa_pkg::WC_W-1:0] wc_r;
  logic                      win_io_r   [pbwa_pkg::WINDOWS];
  logic [AW-1:0]             win_base_r [pbwa_pkg::WINDOWS];
  logic [AW-1:0]             win_size_r [pbwa_pkg::WINDOWS];
  logic [AW-1:0]             nf_r       [pbwa_pkg::WINDOWS];

  // transaction latch
  logic [pbwa_pkg::SLOT_W-1:0] idx_r;
  logic [WW-1:0]               low_r, high_r, mlow_r, mhigh_r;
  logic                        acc_r;

  // working registers
  logic [AW-1:0]             orig_r, bm1_r, bytes_r, addr_r, end_r;
  logic [AW:0]               room_r;
  logic                      bad_r, wrap_r, hit_r;
  logic [pbwa_pkg::WIN_W-1:0] widx_r;

  logic                io, wide, keep, bad_type, pow_bad;
  logic [1:0]          typ;
  logic [AW-1:0]       reach, amask, full_bar, full_mask, orig_c, bm1_c, bytes_c;
  logic [pbwa_pkg::WC_W-1:0] cnt;
  logic                io_cur;
  logic [AW-1:0]       nf_cur, base_cur, size_cur, cursor, cand;
  logic [AW:0]         sum, off, last_byte;
  logic                fit;
  pbwa_pkg::status_t   status_c;
  logic [WW-1:0]       low_c, high_c;
  logic                wu_c;
  logic [AW-1:0]       asg_word;

  assign io   = low_r[0];
  assign typ  = low_r[2:1];
  assign wide = !io && (typ == MEM_TYPE_64);

  always_comb begin
    if (io) begin
      reach = pbwa_pkg::IO_REACH;
    end else if (typ == MEM_TYPE_20) begin
      reach = pbwa_pkg::MEM20_REACH;
    end else if (wide) begin
      reach = pbwa_pkg::MEM64_REACH;
    end else begin
      reach = pbwa_pkg::MEM32_REACH;
    end
  end

  assign amask     = reach & (io ? pbwa_pkg::IO_ALIGN_MASK : pbwa_pkg::MEM_ALIGN_MASK);
  assign full_bar  = {(wide ? high_r : {WW{1'b0}}), low_r};
  assign full_mask = {(wide ? mhigh_r : {WW{1'b0}}), mlow_r};
  assign orig_c    = full_bar & amask;
  assign bm1_c     = ~(full_mask & amask) & reach;
  assign bytes_c   = bm1_c + AW'(1);
  assign pow_bad   = (bytes_c == '0) || (|(bytes_c & bm1_c));
  assign bad_type  = (idx_r >= FIRST_BAD_SLOT) || (io && typ != 2'd0) ||
                     (!io && typ == MEM_TYPE_RSVD) || (wide && idx_r == LAST_SLOT);

  assign cnt  = (wc_r > pbwa_pkg::WC_W'(pbwa_pkg::WINDOWS)) ?
                pbwa_pkg::WC_W'(pbwa_pkg::WINDOWS) : wc_r;
  assign keep = |orig_r;

  assign io_cur   = win_io_r[widx_r];
  assign nf_cur   = nf_r[widx_r];
  assign base_cur = win_base_r[widx_r];
  assign size_cur = win_size_r[widx_r];

  // window stage A: candidate address
  assign cursor = (nf_cur != '0) ? nf_cur : bytes_r;
  assign sum    = {1'b0, cursor} + {1'b0, bm1_r};
  assign cand   = sum[AW-1:0] & ~bm1_r;

  // window stage B: fit check
  assign off       = {1'b0, addr_r} - {1'b0, base_cur};
  assign last_byte = {1'b0, addr_r} + {1'b0, bm1_r};
  assign fit = !off[AW] && !room_r[AW] && (off[AW-1:0] <= room_r[AW-1:0]) &&
               (io_cur == io) && !wrap_r &&
               (keep || (last_byte <= {1'b0, reach}));

  always_comb begin
    stat.bad      = bad_type || pow_bad;
    stat.empty    = (cnt == '0);
    stat.fit      = fit;
    stat.last     = (pbwa_pkg::WC_W'(widx_r) + pbwa_pkg::WC_W'(1)) == cnt;
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
      for (int w = 0; w < pbwa_pkg::WINDOWS; w++) begin
        win_io_r[w]   <= 1'b0;
        win_base_r[w] <= '0;
        win_size_r[w] <= '0;
        nf_r[w]       <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (pbwa_pkg::cfg_idx_t'(cfg_index))
          pbwa_pkg::CFG_WINDOW_COUNT: wc_r <= cfg_data[pbwa_pkg::WC_W-1:0];
          pbwa_pkg::CFG_WIN0_IS_IO:   win_io_r[0] <= cfg_data[0];
          pbwa_pkg::CFG_WIN0_BASE: begin
            win_base_r[0] <= cfg_data;
            nf_r[0]       <= cfg_data;
          end
          pbwa_pkg::CFG_WIN0_SIZE:    win_size_r[0] <= cfg_data;
          pbwa_pkg::CFG_WIN1_IS_IO:   win_io_r[1] <= cfg_data[0];
          pbwa_pkg::CFG_WIN1_BASE: begin
            win_base_r[1] <= cfg_data;
            nf_r[1]       <= cfg_data;
          end
          pbwa_pkg::CFG_WIN1_SIZE:    win_size_r[1] <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        if (status_c == pbwa_pkg::ST_ASSIGNED ||
            (status_c == pbwa_pkg::ST_KEPT && nf_cur < end_r)) begin
          nf_r[widx_r] <= end_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= in_bar_index;
      low_r   <= in_bar_low;
      high_r  <= in_bar_high;
      mlow_r  <= in_mask_low;
      mhigh_r <= in_mask_high;
      acc_r   <= in_device_accepts;
    end
    if (cmd.size_en) begin
      orig_r  <= orig_c;
      bm1_r   <= bm1_c;
      bytes_r <= bytes_c;
      bad_r   <= bad_type || pow_bad;
    end
    if (cmd.win_a_en) begin
      addr_r <= keep ? orig_r : cand;
      wrap_r <= !keep && sum[AW];
      room_r <= {1'b0, size_cur} - {1'b0, bytes_r};
    end
    if (cmd.win_b_en) begin
      end_r <= addr_r + bytes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (cmd.size_en) begin
        widx_r <= '0;
        hit_r  <= 1'b0;
      end else if (cmd.widx_inc) begin
        widx_r <= widx_r + pbwa_pkg::WIN_W'(1);
      end
      if (cmd.win_b_en) begin
        hit_r <= fit;
      end
    end
  end

  assign asg_word = (addr_r & amask) | ({{(AW-WW){1'b0}}, low_r} & ~amask);

  always_comb begin
    if (bad_r) begin
      status_c = pbwa_pkg::ST_INVALID;
    end else if (!hit_r) begin
      status_c = pbwa_pkg::ST_NO_FIT;
    end else if (keep) begin
      status_c = pbwa_pkg::ST_KEPT;
    end else if (!acc_r) begin
      status_c = pbwa_pkg::ST_REFUSED;
    end else begin
      status_c = pbwa_pkg::ST_ASSIGNED;
    end
    low_c  = '0;
    high_c = '0;
    wu_c   = 1'b0;
    if (status_c == pbwa_pkg::ST_KEPT) begin
      low_c  = low_r;
      high_c = wide ? high_r : '0;
      wu_c   = widx_r[0];
    end else if (status_c == pbwa_pkg::ST_ASSIGNED) begin
      low_c  = asg_word[WW-1:0];
      high_c = wide ? addr_r[AW-1:WW] : '0;
      wu_c   = widx_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status        <= status_c;
      out_assigned_low  <= low_c;
      out_assigned_high <= high_c;
      out_window_used   <= wu_c;
    end
  end

endmodule

// ===== src/pci_bar_window_allocator_top.sv =====
// Top level of the PCI BAR window allocator: controller, datapath and checks.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | bar_index, bar_low, bar_high, mask_low,
//          |                      | mask_high, device_accepts
//  out     | out_valid/out_ready  | status, assigned_low, assigned_high,
//          |                      | window_used
//  cfg     | cfg_we               | cfg_index, cfg_data (64 bits)
//
// One transaction at a time; each of the windows scanned (0 to 2) passes
// through stage A, which forms the candidate address, and stage B, which
// does the 64-bit fit compare.
// The result register frees the input side; commit waits only while it is full and not being taken.
// Reset (rst_n low, synchronous) clears all windows, cursors and the controller.
module pci_bar_window_allocator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pbwa_pkg::CFG_IX_W-1:0]      cfg_index,
  input  logic [pbwa_pkg::CFG_D_W-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pbwa_pkg::SLOT_W-1:0]        in_bar_index,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_bar_low,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_bar_high,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_mask_low,
  input  logic [pbwa_pkg::WORD_W-1:0]        in_mask_high,
  input  logic                               in_device_accepts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbwa_pkg::STATUS_W-1:0]      out_status,
  output logic [pbwa_pkg::WORD_W-1:0]        out_assigned_low,
  output logic [pbwa_pkg::WORD_W-1:0]        out_assigned_high,
  output logic                               out_window_used
);

  pbwa_pkg::cmd_t  cmd;
  pbwa_pkg::stat_t stat;

  pbwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbwa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_bar_index      (in_bar_index),
    .in_bar_low        (in_bar_low),
    .in_bar_high       (in_bar_high),
    .in_mask_low       (in_mask_low),
    .in_mask_high      (in_mask_high),
    .in_device_accepts (in_device_accepts),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_assigned_low  (out_assigned_low),
    .out_assigned_high (out_assigned_high),
    .out_window_used   (out_window_used)
  );

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result committed over an untaken result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_failed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pbwa_pkg::ST_KEPT &&
     out_status != pbwa_pkg::ST_ASSIGNED) |->
    (out_assigned_low == '0 && out_assigned_high == '0 && !out_window_used))
    else $error("failed result carries address data");

endmodule
